// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the sorted timeout queue.
// Depends on nothing; the including module must provide clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge once reset is released.
`define STQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define STQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/stq_pkg.sv
// Package of the sorted timeout queue: sizes, command codes and result kinds.
// Depends on nothing.
package stq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] CMD_SET    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [1:0] KIND_CREATED = 2'd0;
  localparam logic [1:0] KIND_FIRED   = 2'd1;
  localparam logic [1:0] KIND_FULL    = 2'd2;
  localparam logic [1:0] KIND_DONE    = 2'd3;

endpackage

// File: rtl/sorted_timeout_queue.sv
// Sorted timeout queue: deadline-ordered timer list with lazy cancel.
// Depends on stq_pkg and assert_macros.svh.
//
//   channel  dir  tdata                                         tuser    tlast
//   s_*      in   current_time[31:0] delay_ms[55:32] handle[59:56] command  -
//   m_*      out  handle_out[3:0]                               kind     last
//
// Set: accept, free-slot search over up to DEPTH slots, insertion scan comparing queued
// entries in order until a later deadline or the list end, insert, result. Cancel and
// a set on a full store go from accept to result. Tick: accept, drop each cancelled
// head, fire each expired head, then the done word (one read port, one comparator).
// Reset is synchronous; it clears the flags and the entry count, not the store.
// Every result word waits in the output register while m_tready is low.
module sorted_timeout_queue
  import stq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // current_time, delay_ms, handle, zero pad
  input  logic [1:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // handle_out, zero pad
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast
);

  `include "assert_macros.svh"

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SLOT     = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_SCAN_CMP = 3'd3;
  localparam logic [2:0] ST_INSERT   = 3'd4;
  localparam logic [2:0] ST_TICK     = 3'd5;
  localparam logic [2:0] ST_TICK_CMP = 3'd6;
  localparam logic [2:0] ST_EMIT     = 3'd7;

  logic [2:0]       state;
  logic [DEPTH-1:0] live;
  logic [DEPTH-1:0] active;
  logic [CNT_W-1:0] entry_count;
  logic [IDX_W-1:0] order [DEPTH];
  logic [31:0]      deadline_mem [DEPTH];

  logic [31:0]      now;
  logic [31:0]      deadline;
  logic [IDX_W-1:0] slot;
  logic [CNT_W-1:0] pos;
  logic [31:0]      rd_data;
  logic [1:0]       res_kind;
  logic [IDX_W-1:0] res_handle;
  logic             res_last;

  logic [32:0]      sum;
  logic [31:0]      sat_deadline;
  logic [3:0]       in_handle;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] rd_addr;
  logic [31:0]      cmp_a;
  logic [31:0]      cmp_b;
  logic             cmp_le;
  logic             out_free;

  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign in_handle = s_tdata[59:56];
  assign head      = order[0];

  assign sum          = {1'b0, s_tdata[31:0]} + {9'd0, s_tdata[55:32]};
  assign sat_deadline = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  assign rd_addr = (state == ST_TICK) ? head : order[pos[IDX_W-1:0]];

  // One comparator serves the insertion scan and the expiry test.
  always_comb begin
    if (state == ST_TICK_CMP) begin
      cmp_a = now;
      cmp_b = rd_data;
    end else begin
      cmp_a = rd_data;
      cmp_b = deadline;
    end
  end
  assign cmp_le = (cmp_a <= cmp_b);

  always_ff @(posedge clk) begin
    if (state == ST_INSERT) begin
      deadline_mem[slot] <= deadline;
    end
    rd_data <= deadline_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      m_tvalid    <= 1'b0;
      live        <= '0;
      active      <= '0;
      entry_count <= '0;
    end else begin
      if (m_tvalid && m_tready && state != ST_EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            now      <= s_tdata[31:0];
            deadline <= sat_deadline;
            slot     <= '0;
            pos      <= '0;
            case (s_tuser)
              CMD_SET: begin
                if (entry_count == CNT_W'(DEPTH)) begin
                  res_kind   <= KIND_FULL;
                  res_handle <= '0;
                  res_last   <= 1'b1;
                  state      <= ST_EMIT;
                end else begin
                  state <= ST_SLOT;
                end
              end
              CMD_CANCEL: begin
                if (32'(in_handle) < DEPTH && live[IDX_W'(in_handle)]) begin
                  active[IDX_W'(in_handle)] <= 1'b0;
                end
                res_kind   <= KIND_DONE;
                res_handle <= '0;
                res_last   <= 1'b1;
                state      <= ST_EMIT;
              end
              CMD_TICK: begin
                state <= ST_TICK;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SLOT: begin
          if (live[slot]) begin
            slot <= slot + 1'b1;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (pos == entry_count) begin
            state <= ST_INSERT;
          end else begin
            state <= ST_SCAN_CMP;
          end
        end
        ST_SCAN_CMP: begin
          if (cmp_le) begin
            pos   <= pos + 1'b1;
            state <= ST_SCAN;
          end else begin
            state <= ST_INSERT;
          end
        end
        ST_INSERT: begin
          for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i) == pos) begin
              order[i] <= slot;
            end else if (i > 0 && CNT_W'(i) > pos) begin
              order[i] <= order[(i > 0) ? i - 1 : 0];
            end
          end
          entry_count  <= entry_count + 1'b1;
          live[slot]   <= 1'b1;
          active[slot] <= 1'b1;
          res_kind     <= KIND_CREATED;
          res_handle   <= slot;
          res_last     <= 1'b1;
          state        <= ST_EMIT;
        end
        ST_TICK: begin
          if (entry_count == '0) begin
            res_kind   <= KIND_DONE;
            res_handle <= '0;
            res_last   <= 1'b1;
            state      <= ST_EMIT;
          end else if (!active[head]) begin
            live[head] <= 1'b0;
            for (int i = 0; i < DEPTH - 1; i++) begin
              order[i] <= order[i + 1];
            end
            entry_count <= entry_count - 1'b1;
          end else begin
            state <= ST_TICK_CMP;
          end
        end
        ST_TICK_CMP: begin
          if (!cmp_le) begin
            live[head]   <= 1'b0;
            active[head] <= 1'b0;
            for (int i = 0; i < DEPTH - 1; i++) begin
              order[i] <= order[i + 1];
            end
            entry_count <= entry_count - 1'b1;
            res_kind    <= KIND_FIRED;
            res_handle  <= head;
            res_last    <= 1'b0;
          end else begin
            res_kind   <= KIND_DONE;
            res_handle <= '0;
            res_last   <= 1'b1;
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_kind;
            m_tdata  <= {4'd0, 4'(res_handle)};
            m_tlast  <= res_last;
            state    <= res_last ? ST_IDLE : ST_TICK;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `STQ_ASSERT(a_count_le_depth, entry_count <= CNT_W'(DEPTH),
              "entry count exceeds the store depth")
  `STQ_ASSERT(a_count_matches_live, $countones(live) == int'(entry_count),
              "queued entry count differs from the number of live slots")
  `STQ_ASSERT(a_insert_free_slot, state == ST_INSERT |-> !live[slot],
              "insertion targets a slot that is already live")
  `STQ_ASSERT(a_scan_in_range, state == ST_SCAN_CMP |-> pos < entry_count,
              "insertion scan compares beyond the queued entries")
  `STQ_ASSERT(a_expiry_on_active_head,
              state == ST_TICK_CMP |-> (entry_count != '0 && active[head]),
              "expiry test on an empty queue or an inactive head")

endmodule
